/* hw/rtl/usf_pkg.sv */
package usf_pkg;

   // bytes in the longest run a group can carry
   localparam int GROUP_BYTES = 4;
   localparam int GIDX_W      = $clog2(GROUP_BYTES);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [7:0] byte_type;

   // one finished run, bytes in stream order, last_idx marks the final byte
   typedef struct packed {
      byte_type [GROUP_BYTES-1:0] bytes;
      logic     [GIDX_W-1:0]      last_idx;
   } group_type;

endpackage

/* hw/rtl/usf_channels.sv */
// input word: one text byte with its end flag
interface usf_req_if;
   import usf_pkg::*;
   logic     valid;
   logic     ready;
   byte_type in_byte;
   logic     end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// result word: one kept byte, flagged on the last byte of its run
interface usf_rsp_if;
   import usf_pkg::*;
   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

/* hw/rtl/usf_front.sv */
module usf_front (
   input  logic               clock,
   input  logic               reset,
   usf_req_if.sink            req_bus,
   input  logic               q_full,
   output logic               q_push,
   output usf_pkg::group_type q_group
);
   import usf_pkg::*;

   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      needed_ff, needed_in;
   logic [1:0]      collected_ff, collected_in;
   logic            allc_ff, allc_in;

   logic            accept;
   byte_type        b;
   logic [1:0]      extra;
   logic            allc_next;
   logic            complete;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && !q_full;
   assign b             = req_bus.in_byte;

   // lead byte class: further bytes the sequence needs
   always_comb begin
      priority if (b[7:5] == 3'b110) extra = 2'd1;
      else if (b[7:4] == 4'b1110)    extra = 2'd2;
      else if (b[7:3] == 5'b11110)   extra = 2'd3;
      else                           extra = 2'd0;
   end

   assign allc_next = allc_ff && (b[7:6] == 2'b10);
   assign complete  = ({1'b0, collected_ff} + 3'd1) >= {1'b0, needed_ff};

   // sequence tracking and group build
   always_comb begin
      held_in      = held_ff;
      needed_in    = needed_ff;
      collected_in = collected_ff;
      allc_in      = allc_ff;
      q_push       = 1'b0;
      q_group.last_idx = '0;
      for (int i = 0; i < GROUP_BYTES; i++) begin
         q_group.bytes[i] = b;
      end
      if (accept) begin
         if (needed_ff == 2'd0) begin
            if (!b[7]) begin
               // ascii passes on its own
               q_push = 1'b1;
            end else if (extra != 2'd0) begin
               held_in[0]   = b;
               needed_in    = extra;
               collected_in = 2'd0;
               allc_in      = 1'b1;
            end
         end else if (complete) begin
            // held bytes first, then this byte
            q_group.bytes[0] = held_ff[0];
            if (collected_ff >= 2'd1) q_group.bytes[1] = held_ff[1];
            if (collected_ff >= 2'd2) q_group.bytes[2] = held_ff[2];
            q_group.last_idx = GIDX_W'(collected_ff + 2'd1);
            q_push       = allc_next;
            needed_in    = 2'd0;
            collected_in = 2'd0;
            allc_in      = 1'b1;
         end else begin
            unique case (collected_ff)
               2'd0:    held_in[1] = b;
               2'd1:    held_in[2] = b;
               default: held_in[0] = held_ff[0];
            endcase
            collected_in = collected_ff + 2'd1;
            allc_in      = allc_next;
         end
         // end of text drops whatever is still open
         if (req_bus.end_of_text) begin
            needed_in    = 2'd0;
            collected_in = 2'd0;
            allc_in      = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         needed_ff    <= 2'd0;
         collected_ff <= 2'd0;
         allc_ff      <= 1'b1;
      end else begin
         needed_ff    <= needed_in;
         collected_ff <= collected_in;
         allc_ff      <= allc_in;
      end
   end

   // held bytes
   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

/* hw/rtl/usf_queue.sv */
module usf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  usf_pkg::group_type push_group,
   input  logic               pop,
   output usf_pkg::group_type head_group,
   output logic               full,
   output logic               empty
);
   import usf_pkg::*;

   group_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty      = count_ff == '0;
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_group = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_group;
   end

endmodule

/* hw/rtl/usf_back.sv */
module usf_back (
   input  logic               clock,
   input  logic               reset,
   input  usf_pkg::group_type head_group,
   input  logic               q_empty,
   output logic               q_pop,
   usf_rsp_if.source          rsp_bus
);
   import usf_pkg::*;

   logic [GIDX_W-1:0] idx_ff, idx_in;
   logic              at_last;
   logic              take;

   assign at_last          = idx_ff == head_group.last_idx;
   assign rsp_bus.valid    = !q_empty;
   assign rsp_bus.out_byte = head_group.bytes[idx_ff];
   assign rsp_bus.run_last = at_last;
   assign take             = rsp_bus.valid && rsp_bus.ready;
   assign q_pop            = take && at_last;

   // walk the head run one word at a time
   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = at_last ? '0 : idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

/* hw/rtl/utf8_sequence_filter_top.sv */
// channel | dir | payload              | accept
// req_bus | in  | in_byte, end_of_text | valid && ready
// rsp_bus | out | out_byte, run_last   | valid && ready
//
// one input word per cycle while the run queue has room; a finished run leaves one byte at a time
// sustained rate is one word in and one word out per cycle, held back by output stalls
// the completing input word writes its run into the registered queue; output reads the head
// synchronous reset empties the four-run queue and drops any open sequence
// input stalls only while the run queue is full; output stall holds the word
module utf8_sequence_filter_top (
   input  logic     clock,
   input  logic     reset,
   usf_req_if.sink  req_bus,
   usf_rsp_if.source rsp_bus
);
   import usf_pkg::*;

   logic      q_full;
   logic      q_empty;
   logic      q_push;
   logic      q_pop;
   group_type push_group;
   group_type head_group;

   // classify and assemble runs
   usf_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_group (push_group)
   );

   // run queue
   usf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_group (push_group),
      .pop        (q_pop),
      .head_group (head_group),
      .full       (q_full),
      .empty      (q_empty)
   );

   // serialize runs to the output
   usf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_group (head_group),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

/* hw/rtl/usf_checker.sv */
module usf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last
);

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output word offered after reset");

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last))
      else $error("stalled output word changed");

   // the rest of a run is already queued when its first words go
   a_run_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last |=> rsp_valid)
      else $error("run broken off");

   // only lead or continuation bytes precede the end of a run
   a_mid_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> rsp_out_byte[7])
      else $error("ascii byte inside a run");

   // a run never ends on a lead byte
   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last |-> rsp_out_byte[7:6] != 2'b11)
      else $error("run ends on a lead byte");

endmodule

bind utf8_sequence_filter_top usf_checker u_usf_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_out_byte (rsp_bus.out_byte),
   .rsp_run_last (rsp_bus.run_last)
);

/* tb/utf8_sequence_filter_checker.sv */
module utf8_sequence_filter_checker (
   input  logic clock,
   input  logic reset,
   usf_req_if   req_mon,
   usf_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import usf_pkg::*;

   // byte classes
   localparam byte_type ASCII_MASK = 8'h80;
   localparam byte_type CONT_MASK  = 8'hC0;
   localparam byte_type CONT_TAG   = 8'h80;
   localparam byte_type LEAD2_MASK = 8'hE0;
   localparam byte_type LEAD2_TAG  = 8'hC0;
   localparam byte_type LEAD3_MASK = 8'hF0;
   localparam byte_type LEAD3_TAG  = 8'hE0;
   localparam byte_type LEAD4_MASK = 8'hF8;
   localparam byte_type LEAD4_TAG  = 8'hF0;
   localparam int       REPORT_MAX = 10;

   typedef struct packed {
      byte_type value;
      logic     run_end;
   } kept_word_type;

   // predicted filter state
   byte_type   held [3];
   logic [1:0] need_count;
   logic [1:0] got_count;
   logic       all_cont;

   kept_word_type kept_words [$];
   int            mismatches;
   int            words_seen;

   task automatic keep_byte(byte_type value, logic run_end);
      kept_word_type w;
      w.value   = value;
      w.run_end = run_end;
      kept_words.push_back(w);
   endtask

   task automatic close_sequence();
      need_count = 2'd0;
      got_count  = 2'd0;
      all_cont   = 1'b1;
   endtask

   // expected kept bytes for one input word
   task automatic predict_filter(byte_type b, logic eot);
      if (need_count == 2'd0) begin
         if ((b & ASCII_MASK) == 8'h00) begin
            keep_byte(b, 1'b1);
         end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            held[0] = b;
            need_count = 2'd1;
            got_count = 2'd0;
            all_cont = 1'b1;
         end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            held[0] = b;
            need_count = 2'd2;
            got_count = 2'd0;
            all_cont = 1'b1;
         end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            held[0] = b;
            need_count = 2'd3;
            got_count = 2'd0;
            all_cont = 1'b1;
         end
      end else begin
         if ((b & CONT_MASK) != CONT_TAG) all_cont = 1'b0;
         if (int'(got_count) + 1 >= int'(need_count)) begin
            // sequence complete: emit all or nothing
            if (all_cont) begin
               for (int i = 0; i <= int'(got_count); i++) keep_byte(held[i], 1'b0);
               keep_byte(b, 1'b1);
            end
            close_sequence();
         end else begin
            held[int'(got_count) + 1] = b;
            got_count = got_count + 2'd1;
         end
      end
      if (eot) close_sequence();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         close_sequence();
         for (int i = 0; i < 3; i++) held[i] = 8'h00;
         kept_words.delete();
         mismatches = 0;
         words_seen = 0;
      end else begin
         // compare an accepted result word with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (kept_words.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("word %0d: unexpected, got byte %02h last %0b",
                           words_seen, rsp_mon.out_byte, rsp_mon.run_last);
            end else begin
               kept_word_type want;
               want = kept_words.pop_front();
               if (rsp_mon.out_byte !== want.value || rsp_mon.run_last !== want.run_end) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("word %0d: expected byte %02h last %0b, got byte %02h last %0b",
                              words_seen, want.value, want.run_end,
                              rsp_mon.out_byte, rsp_mon.run_last);
               end
            end
            words_seen++;
         end
         // new predictions for an accepted input word
         if (req_mon.valid && req_mon.ready)
            predict_filter(req_mon.in_byte, req_mon.end_of_text);
      end
      fail_count    <= mismatches;
      pending_words <= kept_words.size();
   end

endmodule

/* tb/utf8_sequence_filter_top_tb.sv */
module utf8_sequence_filter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import usf_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_WORDS = 84;
   localparam int DRAIN_CYCLES = 8;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_words;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   words_sent;
   int   stall_cycles;

   usf_req_if req_bus ();
   usf_rsp_if rsp_bus ();

   utf8_sequence_filter_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   utf8_sequence_filter_checker filter_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("utf8_sequence_filter_top: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // send one word, idling at random first; valid stays up for the next call
   task automatic push_word(byte_type b, logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.in_byte     <= b;
      req_bus.end_of_text <= eot;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
   endtask

   function automatic logic random_eot();
      return ($urandom_range(24) == 0);
   endfunction

   function automatic byte_type cont_byte();
      return {2'b10, 6'($urandom)};
   endfunction

   // lead byte for a run with n further bytes
   function automatic byte_type lead_byte(int n);
      if (n == 1) return {3'b110, 5'($urandom)};
      if (n == 2) return {4'b1110, 4'($urandom)};
      return {5'b11110, 3'($urandom)};
   endfunction

   initial begin
      int kind;
      int n;
      reset               = 1'b1;
      words_sent          = 0;
      send_idle_pct       = 18;
      recv_idle_pct       = 60;
      req_bus.valid       <= 1'b0;
      req_bus.in_byte     <= 8'h00;
      req_bus.end_of_text <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // ascii extremes, eot on plain ascii
      push_word(8'h00, 1'b0);
      push_word(8'h7F, 1'b1);
      // well-formed runs of 2, 3 and 4 bytes
      push_word(8'hC2, 1'b0);
      push_word(8'hA9, 1'b0);
      push_word(8'hEF, 1'b0);
      push_word(8'hBF, 1'b0);
      push_word(8'h80, 1'b1);
      push_word(8'hF7, 1'b0);
      push_word(8'h9F, 1'b0);
      push_word(8'h98, 1'b0);
      push_word(8'hBF, 1'b0);
      // stray continuation and invalid leads
      push_word(8'h80, 1'b0);
      push_word(8'hF8, 1'b0);
      push_word(8'hFF, 1'b0);
      // bad run swallowing an ascii byte
      push_word(8'hE2, 1'b0);
      push_word(8'h41, 1'b0);
      push_word(8'h82, 1'b0);
      // lead inside an open run
      push_word(8'hC3, 1'b0);
      push_word(8'hC3, 1'b0);
      // eot with a run still open, then on a lead byte
      push_word(8'hF0, 1'b0);
      push_word(8'h9F, 1'b1);
      push_word(8'h55, 1'b0);
      push_word(8'hC0, 1'b1);
      push_word(8'h2A, 1'b0);

      // random text, three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 60;
            recv_idle_pct = 18;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         while (words_sent < (phase + 1) * PHASE_WORDS) begin
            kind = $urandom_range(99);
            n = $urandom_range(1, 3);
            if (kind < 35) begin
               push_word({1'b0, 7'($urandom)}, random_eot());
            end else if (kind < 80) begin
               push_word(lead_byte(n), random_eot());
               repeat (n) push_word(cont_byte(), random_eot());
            end else if (kind < 90) begin
               // broken run, some collected bytes of any value
               push_word(lead_byte(n), random_eot());
               repeat (n) push_word(($urandom_range(2) == 0) ? 8'($urandom) : cont_byte(),
                                    random_eot());
            end else begin
               push_word(8'($urandom), random_eot());
            end
         end
      end
      req_bus.valid <= 1'b0;
      @(posedge clock);

      // drain
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("utf8_sequence_filter_top: match");
      end else begin
         $display("utf8_sequence_filter_top: mismatch");
      end
      $finish;
   end

endmodule
